### hw/rtl/rplt_pkg.sv
// ----------------------------------------------------------------------------
// rplt_pkg
// Shared types and constants for the reuse-port listener table.
// ----------------------------------------------------------------------------
package rplt_pkg;

  localparam int unsigned SlotsPerPortDef = 4;
  localparam int unsigned PortCountDef    = 65536;
  localparam int unsigned SockCountDef    = 1024;

  localparam int unsigned PortW = 16;
  localparam int unsigned SidW  = 10;
  localparam int unsigned IpW   = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_ATTR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INUSE = 2'd1,
    ST_NONE  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]     kind;
    logic [PortW-1:0] port;
    logic [SidW-1:0]  sock_id;
    logic           ask_reuseport;
    logic [IpW-1:0] ip_addr;
    logic           sock_reuse;
    logic           sock_listening;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [SidW-1:0] found_sock;
  } rsp_t;

endpackage

### hw/rtl/rplt_stream_if.sv
// ----------------------------------------------------------------------------
// rplt_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface rplt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/rplt_ram.sv
// ----------------------------------------------------------------------------
// rplt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rplt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### hw/rtl/reuseport_listener_table.sv
// ----------------------------------------------------------------------------
// reuseport_listener_table
// Flow: an attribute write or unusable port is answered without a table read; insert and lookup
// read the port count, then a slot and its socket attributes per slot; remove reads slots and shifts.
// Throughput: one beat in flight; no new beat is taken until the result beat is accepted.
// Reset: port counts and socket attributes are cleared by concurrent sweeps over
// PORT_COUNT and SOCK_COUNT entries; no item taken until both end.
// ----------------------------------------------------------------------------
module reuseport_listener_table #(
  parameter int unsigned SLOTS_PER_PORT = rplt_pkg::SlotsPerPortDef,
  parameter int unsigned PORT_COUNT     = rplt_pkg::PortCountDef,
  parameter int unsigned SOCK_COUNT     = rplt_pkg::SockCountDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  rplt_stream_if.sink   req,
  rplt_stream_if.source rsp
);
  localparam int unsigned SlotW  = (SLOTS_PER_PORT > 1) ? $clog2(SLOTS_PER_PORT) : 1;
  localparam int unsigned CntW   = $clog2(SLOTS_PER_PORT + 1);
  localparam int unsigned PaW    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int unsigned SaW    = (SOCK_COUNT > 1) ? $clog2(SOCK_COUNT) : 1;
  localparam int unsigned SlotDepth = PORT_COUNT * SLOTS_PER_PORT;
  localparam int unsigned SlAW   = $clog2(SlotDepth);
  localparam int unsigned AttrW  = rplt_pkg::IpW + 2;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_PWAIT = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SWAIT = 4'd5;
  localparam logic [3:0] S_ARD   = 4'd6;
  localparam logic [3:0] S_AWAIT = 4'd7;
  localparam logic [3:0] S_SHIFT = 4'd8;
  localparam logic [3:0] S_SHW   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;
  rplt_pkg::req_t req_q;
  logic [PaW:0] pclr_q, pclr_d;
  logic [SaW:0] sclr_q, sclr_d;
  logic [CntW-1:0] n_q, n_d;
  logic [SlotW-1:0] rot_q, rot_d;
  logic [CntW-1:0] i_q, i_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic [rplt_pkg::SidW-1:0] sid_q, sid_d;
  logic out_v_q, out_v_d;
  rplt_pkg::rsp_t out_q, out_d;

  // memory ports
  logic pc_we; logic [PaW-1:0] pc_a; logic [CntW+SlotW-1:0] pc_wd, pc_rd;
  logic sl_we; logic [SlAW-1:0] sl_a; logic [rplt_pkg::SidW-1:0] sl_wd, sl_rd;
  logic at_we; logic [SaW-1:0] at_a; logic [AttrW-1:0] at_wd, at_rd;

  rplt_ram #(.Width(CntW+SlotW), .Depth(PORT_COUNT)) u_pc (
    .clk_i, .we_i(pc_we), .addr_i(pc_a), .wdata_i(pc_wd), .rdata_o(pc_rd));
  rplt_ram #(.Width(rplt_pkg::SidW), .Depth(SlotDepth)) u_sl (
    .clk_i, .we_i(sl_we), .addr_i(sl_a), .wdata_i(sl_wd), .rdata_o(sl_rd));
  rplt_ram #(.Width(AttrW), .Depth(SOCK_COUNT)) u_at (
    .clk_i, .we_i(at_we), .addr_i(at_a), .wdata_i(at_wd), .rdata_o(at_rd));

  logic port_ok, sid_ok, cur_ok;
  logic [SlotW-1:0] ridx;
  logic [CntW:0] rsum;

  assign port_ok = (req_q.port != '0) &&
                   ({16'd0, req_q.port} < 32'(PORT_COUNT));
  assign sid_ok  = {22'd0, req_q.sock_id} < 32'(SOCK_COUNT);
  assign cur_ok  = {22'd0, sl_rd} < 32'(SOCK_COUNT);
  assign rsum = (CntW+1)'(rot_q) + (CntW+1)'(i_q);
  assign ridx = (rsum >= (CntW+1)'(n_q)) ? SlotW'(rsum - (CntW+1)'(n_q))
                                         : SlotW'(rsum);

  function automatic logic [SlAW-1:0] slot_addr(input logic [rplt_pkg::PortW-1:0] p,
                                                input logic [SlotW-1:0] s);
    logic [SlAW+SlotW:0] a;
    a = (SlAW+SlotW+1)'(p) * (SlAW+SlotW+1)'(SLOTS_PER_PORT) + (SlAW+SlotW+1)'(s);
    return a[SlAW-1:0];
  endfunction

  assign req.ready = (state_q == S_IDLE) && !out_v_q;
  assign rsp.valid = out_v_q;
  assign rsp.data  = out_q;

  always_comb begin
    state_d = state_q; pclr_d = pclr_q; sclr_d = sclr_q;
    n_d = n_q; rot_d = rot_q; i_d = i_q; idx_d = idx_q; sid_d = sid_q;
    out_v_d = out_v_q; out_d = out_q;
    pc_we = 1'b0; pc_a = req_q.port[PaW-1:0]; pc_wd = '0;
    sl_we = 1'b0; sl_a = '0; sl_wd = req_q.sock_id;
    at_we = 1'b0; at_a = SaW'(req_q.sock_id); at_wd = '0;
    if (out_v_q && rsp.ready) out_v_d = 1'b0;
    case (state_q)
      S_CLR: begin
        if (pclr_q < (PaW+1)'(PORT_COUNT)) begin
          pc_we = 1'b1; pc_a = pclr_q[PaW-1:0]; pclr_d = pclr_q + 1'b1;
        end
        if (sclr_q < (SaW+1)'(SOCK_COUNT)) begin
          at_we = 1'b1; at_a = sclr_q[SaW-1:0]; sclr_d = sclr_q + 1'b1;
        end
        if (pclr_q >= (PaW+1)'(PORT_COUNT) && sclr_q >= (SaW+1)'(SOCK_COUNT))
          state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid && req.ready) state_d = S_PRD;
      end
      S_PRD: begin
        out_d = '{status: rplt_pkg::ST_OK, found_sock: '0};
        if (req_q.kind == rplt_pkg::KIND_ATTR) begin
          if (sid_ok) begin
            at_we = 1'b1;
            at_wd = {req_q.sock_reuse, req_q.sock_listening, req_q.ip_addr};
          end
          state_d = S_DONE;
        end else if (!port_ok) begin
          out_d.status = (req_q.kind == rplt_pkg::KIND_INSERT) ? rplt_pkg::ST_INUSE :
                         (req_q.kind == rplt_pkg::KIND_LOOKUP) ? rplt_pkg::ST_NONE :
                                                                 rplt_pkg::ST_OK;
          state_d = S_DONE;
        end else begin
          state_d = S_PWAIT;
        end
      end
      S_PWAIT: begin
        n_d = pc_rd[CntW+SlotW-1:SlotW]; rot_d = pc_rd[SlotW-1:0]; i_d = '0;
        state_d = S_SRD;
        if (req_q.kind == rplt_pkg::KIND_INSERT) begin
          if (!sid_ok) begin
            out_d.status = rplt_pkg::ST_INUSE; state_d = S_DONE;
          end else if (pc_rd[CntW+SlotW-1:SlotW] == '0) begin
            sl_we = 1'b1; sl_a = slot_addr(req_q.port, '0);
            pc_we = 1'b1; pc_wd = {CntW'(1), SlotW'(0)};
            state_d = S_DONE;
          end else if (!req_q.ask_reuseport ||
                       pc_rd[CntW+SlotW-1:SlotW] >= CntW'(SLOTS_PER_PORT)) begin
            out_d.status = rplt_pkg::ST_INUSE; state_d = S_DONE;
          end
        end else if (req_q.kind == rplt_pkg::KIND_LOOKUP &&
                     pc_rd[CntW+SlotW-1:SlotW] == '0) begin
          out_d.status = rplt_pkg::ST_NONE; state_d = S_DONE;
        end
      end
      S_SRD: begin
        if (i_q >= n_q) begin
          if (req_q.kind == rplt_pkg::KIND_INSERT) begin
            sl_we = 1'b1; sl_a = slot_addr(req_q.port, SlotW'(n_q));
            pc_we = 1'b1; pc_wd = {n_q + 1'b1, rot_q};
          end else if (req_q.kind == rplt_pkg::KIND_LOOKUP) begin
            out_d.status = rplt_pkg::ST_NONE;
          end
          state_d = S_DONE;
        end else begin
          idx_d = (req_q.kind == rplt_pkg::KIND_LOOKUP) ? ridx : SlotW'(i_q);
          sl_a = slot_addr(req_q.port, idx_d);
          state_d = S_SWAIT;
        end
      end
      S_SWAIT: begin
        sid_d = sl_rd;
        if (req_q.kind == rplt_pkg::KIND_REMOVE) begin
          if (sl_rd == req_q.sock_id) begin
            state_d = S_SHIFT;
          end else begin
            i_d = i_q + 1'b1; state_d = S_SRD;
          end
        end else if (!cur_ok) begin
          if (req_q.kind == rplt_pkg::KIND_INSERT) begin
            out_d.status = rplt_pkg::ST_INUSE; state_d = S_DONE;
          end else begin
            i_d = i_q + 1'b1; state_d = S_SRD;
          end
        end else begin
          at_a = SaW'(sl_rd); state_d = S_AWAIT;
        end
      end
      S_AWAIT: begin
        if (req_q.kind == rplt_pkg::KIND_INSERT) begin
          if (!at_rd[AttrW-1]) begin
            out_d.status = rplt_pkg::ST_INUSE; state_d = S_DONE;
          end else begin
            i_d = i_q + 1'b1; state_d = S_SRD;
          end
        end else if (at_rd[AttrW-2] &&
                     (at_rd[rplt_pkg::IpW-1:0] == '0 ||
                      at_rd[rplt_pkg::IpW-1:0] == req_q.ip_addr)) begin
          out_d.found_sock = sid_q;
          pc_we = 1'b1;
          pc_wd = {n_q, ((CntW'(idx_q) + 1'b1) >= n_q) ? SlotW'(0)
                                                        : SlotW'(idx_q + 1'b1)};
          state_d = S_DONE;
        end else begin
          i_d = i_q + 1'b1; state_d = S_SRD;
        end
      end
      S_SHIFT: begin
        // i_q is the hole; pull slot i+1 down
        if (i_q + 1'b1 >= n_q) begin
          pc_we = 1'b1;
          pc_wd = {n_q - 1'b1, (CntW'(rot_q) >= n_q - 1'b1) ? SlotW'(0) : rot_q};
          state_d = S_DONE;
        end else begin
          sl_a = slot_addr(req_q.port, SlotW'(i_q + 1'b1));
          state_d = S_SHW;
        end
      end
      S_SHW: begin
        sl_we = 1'b1; sl_a = slot_addr(req_q.port, SlotW'(i_q)); sl_wd = sl_rd;
        i_d = i_q + 1'b1; state_d = S_SHIFT;
      end
      S_DONE: begin
        if (!out_v_q) begin
          out_v_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; pclr_q <= '0; sclr_q <= '0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; pclr_q <= pclr_d; sclr_q <= sclr_d; out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) req_q <= req.data;
    n_q <= n_d; rot_q <= rot_d; i_q <= i_d; idx_q <= idx_d; sid_q <= sid_d;
    out_q <= out_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> state_q == S_IDLE) else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !rsp.valid || $past(rsp.valid))
    else $error("result without work");
  a_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> rsp.data.status != rplt_pkg::ST_RSVD) else $error("bad status");
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.data.status != rplt_pkg::ST_OK) |-> rsp.data.found_sock == '0)
    else $error("found on failure");
endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reuse-port listener table. Directed and random
// insert/remove/lookup/attribute beats, an internal table predictor, and a
// scoreboard that compares every response beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Slots = rplt_pkg::SlotsPerPortDef;
  localparam int unsigned Ports = rplt_pkg::PortCountDef;
  localparam int unsigned Socks = rplt_pkg::SockCountDef;
  localparam int unsigned SidW  = rplt_pkg::SidW;
  localparam int unsigned IpW   = rplt_pkg::IpW;
  localparam int unsigned Limit = 200000;

  class table_scoreboard;
    logic [SidW-1:0] slot_tbl [int][Slots];
    int unsigned     used_cnt [int];
    int unsigned     rot_ptr  [int];
    bit              reuse_fl [Socks];
    bit              listen_fl[Socks];
    logic [IpW-1:0]  bound_ip [Socks];
    rplt_pkg::rsp_t  pending[$];
    int              errors;

    function int unsigned count_of(int p);
      return used_cnt.exists(p) ? used_cnt[p] : 0;
    endfunction

    function void note_request(rplt_pkg::req_t r);
      rplt_pkg::rsp_t e;
      int p, n, idx, sid;
      bit ok;
      e = '0;
      p = int'(r.port);
      n = count_of(p);
      case (rplt_pkg::kind_e'(r.kind))
        rplt_pkg::KIND_INSERT: begin
          e.status = rplt_pkg::ST_INUSE;
          if (p != 0 && p < Ports && r.sock_id < Socks) begin
            if (n == 0) begin
              slot_tbl[p][0] = r.sock_id;
              used_cnt[p] = 1;
              rot_ptr[p] = 0;
              e.status = rplt_pkg::ST_OK;
            end else if (r.ask_reuseport && n < Slots) begin
              ok = 1;
              for (int i = 0; i < n; i++)
                if (!reuse_fl[slot_tbl[p][i]]) ok = 0;
              if (ok) begin
                slot_tbl[p][n] = r.sock_id;
                used_cnt[p] = n + 1;
                e.status = rplt_pkg::ST_OK;
              end
            end
          end
        end
        rplt_pkg::KIND_REMOVE: begin
          if (p != 0 && p < Ports) begin
            idx = -1;
            for (int i = 0; i < n; i++)
              if (idx < 0 && slot_tbl[p][i] == r.sock_id) idx = i;
            if (idx >= 0) begin
              for (int i = idx; i + 1 < n; i++) slot_tbl[p][i] = slot_tbl[p][i+1];
              used_cnt[p] = n - 1;
              if (rot_ptr[p] >= n - 1) rot_ptr[p] = 0;
            end
          end
        end
        rplt_pkg::KIND_LOOKUP: begin
          e.status = rplt_pkg::ST_NONE;
          if (p != 0 && p < Ports) begin
            for (int i = 0; i < n; i++) begin
              idx = (rot_ptr[p] + i) % n;
              sid = int'(slot_tbl[p][idx]);
              if (listen_fl[sid] &&
                  (bound_ip[sid] == 0 || bound_ip[sid] == r.ip_addr)) begin
                rot_ptr[p] = (idx + 1) % n;
                e.status = rplt_pkg::ST_OK;
                e.found_sock = SidW'(sid);
                break;
              end
            end
          end
        end
        default: begin
          reuse_fl[r.sock_id] = r.sock_reuse;
          listen_fl[r.sock_id] = r.sock_listening;
          bound_ip[r.sock_id] = r.ip_addr;
        end
      endcase
      pending.push_back(e);
    endfunction

    function void check_response(rplt_pkg::rsp_t a);
      rplt_pkg::rsp_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat status=%0d sock=%0d", a.status, a.found_sock);
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status || a.found_sock !== e.found_sock) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp status=%0d sock=%0d, got status=%0d sock=%0d",
                   e.status, e.found_sock, a.status, a.found_sock);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   src_idle;
  int   snk_idle;
  int   quiet;
  table_scoreboard sb;

  rplt_stream_if #(.T(rplt_pkg::req_t)) req ();
  rplt_stream_if #(.T(rplt_pkg::rsp_t)) rsp ();

  reuseport_listener_table dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .rsp   (rsp.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    req.valid = 1'b0;
    req.data  = '0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rsp.valid && rsp.ready) sb.check_response(rsp.data);
    rsp.ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= Limit) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send(rplt_pkg::req_t r);
    while ($urandom_range(99) < src_idle) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.data  <= r;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(r);
  endtask

  function automatic rplt_pkg::req_t mk(rplt_pkg::kind_e k, int p, int s, int ask,
                                        logic [IpW-1:0] ip, int ru, int li);
    rplt_pkg::req_t r;
    r.kind = k;
    r.port = 16'(p);
    r.sock_id = SidW'(s);
    r.ask_reuseport = 1'(ask);
    r.ip_addr = ip;
    r.sock_reuse = 1'(ru);
    r.sock_listening = 1'(li);
    return r;
  endfunction

  function automatic rplt_pkg::req_t rand_req();
    rplt_pkg::req_t r;
    int unsigned sel;
    logic [IpW-1:0] ips [4] = '{32'h0, 32'h0a000001, 32'hc0a80001, 32'hffffffff};
    r = '0;
    r.ask_reuseport = 1'($urandom_range(1));
    r.sock_reuse = 1'($urandom_range(1));
    r.sock_listening = 1'($urandom_range(1));
    r.port = 16'($urandom_range(1, 6));
    r.sock_id = SidW'($urandom_range(0, 15));
    r.ip_addr = ips[$urandom_range(1, 3)];
    sel = $urandom_range(99);
    if (sel < 30) begin
      r.kind = rplt_pkg::KIND_INSERT;
      r.ask_reuseport = ($urandom_range(9) != 0);
    end else if (sel < 50) begin
      r.kind = rplt_pkg::KIND_REMOVE;
    end else if (sel < 80) begin
      r.kind = rplt_pkg::KIND_LOOKUP;
    end else begin
      r.kind = rplt_pkg::KIND_ATTR;
      r.ip_addr = ips[$urandom_range(0, 3)];
      if ($urandom_range(3) == 0) r.ip_addr = $urandom;
      r.sock_reuse = ($urandom_range(4) != 0);
    end
    if ($urandom_range(19) == 0) r.port = 16'($urandom);
    if ($urandom_range(19) == 0) r.sock_id = SidW'($urandom);
    return r;
  endfunction

  initial begin
    sb = new();
    src_idle = 35;
    snk_idle = 53;
    quiet = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(mk(rplt_pkg::KIND_ATTR, 1, 1, 0, 0, 1, 1));
    send(mk(rplt_pkg::KIND_ATTR, 2, 2, 0, 32'h0a000001, 1, 1));
    send(mk(rplt_pkg::KIND_ATTR, 3, 1023, 0, 32'hffffffff, 0, 1));
    send(mk(rplt_pkg::KIND_INSERT, 0, 1, 1, 0, 0, 0));
    send(mk(rplt_pkg::KIND_INSERT, 65535, 1, 1, 0, 0, 0));
    send(mk(rplt_pkg::KIND_INSERT, 65535, 2, 1, 0, 0, 0));
    send(mk(rplt_pkg::KIND_INSERT, 65535, 3, 0, 0, 0, 0));
    send(mk(rplt_pkg::KIND_INSERT, 65535, 4, 1, 0, 0, 0));
    send(mk(rplt_pkg::KIND_INSERT, 65535, 5, 1, 0, 0, 0));
    send(mk(rplt_pkg::KIND_INSERT, 65535, 6, 1, 0, 0, 0));
    send(mk(rplt_pkg::KIND_LOOKUP, 65535, 0, 0, 32'h0a000001, 0, 0));
    send(mk(rplt_pkg::KIND_LOOKUP, 65535, 0, 0, 32'h0a000002, 0, 0));
    send(mk(rplt_pkg::KIND_LOOKUP, 65535, 0, 0, 32'h0a000001, 0, 0));
    send(mk(rplt_pkg::KIND_LOOKUP, 0, 0, 0, 0, 0, 0));
    send(mk(rplt_pkg::KIND_REMOVE, 65535, 1, 0, 0, 0, 0));
    send(mk(rplt_pkg::KIND_REMOVE, 65535, 9, 0, 0, 0, 0));
    send(mk(rplt_pkg::KIND_REMOVE, 0, 2, 0, 0, 0, 0));
    send(mk(rplt_pkg::KIND_INSERT, 7, 1023, 0, 0, 0, 0));
    send(mk(rplt_pkg::KIND_INSERT, 7, 1, 1, 0, 0, 0));
    send(mk(rplt_pkg::KIND_LOOKUP, 7, 0, 0, 32'h12345678, 0, 0));
    send(mk(rplt_pkg::KIND_LOOKUP, 8, 0, 0, 32'h0, 0, 0));
    send(mk(rplt_pkg::KIND_REMOVE, 65535, 2, 0, 0, 0, 0));
    send(mk(rplt_pkg::KIND_LOOKUP, 65535, 0, 0, 32'hffffffff, 0, 0));

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 35 : (ph == 1) ? 53 : 0;
      snk_idle = (ph == 0) ? 53 : (ph == 1) ? 35 : 0;
      for (int i = 0; i < 410; i++) send(rand_req());
    end
    req.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/rplt_pkg.sv
hw/rtl/rplt_stream_if.sv
hw/rtl/rplt_ram.sv
hw/rtl/reuseport_listener_table.sv
test/tb.sv
